[rtl/core/atcd_pkg.sv]
// Shared types and codes for the ATC texture block decoder.
package atcd_pkg;

    typedef enum logic [1:0] {
        MODE_OPAQUE   = 2'd0,
        MODE_EXPLICIT = 2'd1,
        MODE_INTERP   = 2'd2,
        MODE_OFF      = 2'd3
    } t_alpha_mode;

    typedef logic [3:0][23:0] t_pal;
    typedef logic [7:0][7:0]  t_atab;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } t_stage_ctl;

    typedef struct packed {
        t_pal        pal;
        t_atab       atab;
        logic [31:0] idx;
        logic [63:0] abits;
        t_alpha_mode mode;
    } t_ctx;

endpackage

[rtl/core/atcd_palette.sv]
// Two-stage colour palette builder: channel widening, blends and variant entry.
module atcd_palette (
    input  logic                 i_clk,
    input  atcd_pkg::t_stage_ctl i_ctl,
    input  logic [15:0]          i_color_a,
    input  logic [15:0]          i_color_b,
    output atcd_pkg::t_pal       o_pal
);
    import atcd_pkg::*;

    localparam logic [13:0] InterpMul = 14'd21;

    logic [7:0] red0, green0, blue0, red1, green1, blue1;
    logic [5:0][9:0]  sum;
    logic [5:0][13:0] n_prod;
    logic [8:0]  blue_diff;
    logic [7:0]  red_var;
    logic [9:0]  green_diff;
    logic [23:0] n_var_entry;

    logic [5:0][13:0] r_prod;
    logic [23:0] r_var_entry;
    logic [23:0] r_col0;
    logic [23:0] r_col1;
    logic        r_variant;
    t_pal        n_pal;
    t_pal        r_pal;

    assign red0   = {i_color_a[14:10], 3'b000};
    assign green0 = {i_color_a[9:4], i_color_a[9:8]};
    assign blue0  = {i_color_a[4:0], 3'b000};
    assign red1   = {i_color_b[15:11], 3'b000};
    assign green1 = {i_color_b[10:5], i_color_b[10:9]};
    assign blue1  = {i_color_b[4:0], 3'b000};

    always_comb begin
        sum[0] = {1'b0, red0, 1'b0}   + {2'b00, red1};
        sum[1] = {1'b0, green0, 1'b0} + {2'b00, green1};
        sum[2] = {1'b0, blue0, 1'b0}  + {2'b00, blue1};
        sum[3] = {1'b0, red1, 1'b0}   + {2'b00, red0};
        sum[4] = {1'b0, green1, 1'b0} + {2'b00, green0};
        sum[5] = {1'b0, blue1, 1'b0}  + {2'b00, blue0};
        for (int i = 0; i < 6; i++) begin
            n_prod[i] = {4'b0000, sum[i]} * InterpMul;
        end
    end

    // The blue borrow runs on into red, as it does on the packed word.
    assign blue_diff   = {1'b0, blue0} - {3'b000, blue1[7:2]};
    assign red_var     = red0 - {2'b00, red1[7:2]} - {7'b0000000, blue_diff[8]};
    assign green_diff  = {green0, 2'b00} - {2'b00, green1};
    assign n_var_entry = {red_var, green_diff[9:2], blue_diff[7:0]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_load) begin
            r_prod      <= n_prod;
            r_var_entry <= n_var_entry;
            r_col0      <= {red0, green0, blue0};
            r_col1      <= {red1, green1, blue1};
            r_variant   <= i_color_a[15];
        end
    end

    always_comb begin
        if (r_variant) begin
            n_pal[0] = 24'd0;
            n_pal[1] = r_var_entry;
            n_pal[2] = r_col0;
        end else begin
            n_pal[0] = r_col0;
            n_pal[1] = {r_prod[0][13:6], r_prod[1][13:6], r_prod[2][13:6]};
            n_pal[2] = {r_prod[3][13:6], r_prod[4][13:6], r_prod[5][13:6]};
        end
        n_pal[3] = r_col1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_load) begin
            r_pal <= n_pal;
        end
    end

    assign o_pal = r_pal;

endmodule

[rtl/core/atcd_alpha.sv]
// Two-stage alpha table builder: weighted sums, then division by five or seven.
module atcd_alpha (
    input  logic                 i_clk,
    input  atcd_pkg::t_stage_ctl i_ctl,
    input  logic [15:0]          i_endpoints,
    output atcd_pkg::t_atab      o_atab
);
    import atcd_pkg::*;

    localparam logic [22:0] Recip7 = 23'd2341;
    localparam logic [22:0] Recip5 = 23'd1639;
    localparam int          Shift7 = 14;
    localparam int          Shift5 = 13;

    logic [7:0] a0, a1;
    logic       ge;
    logic [5:0][10:0] n_sum;
    logic [5:0][10:0] r_sum;
    logic       r_ge;
    logic [7:0] r_a0, r_a1;
    logic [5:0][22:0] q7;
    logic [5:0][22:0] q5;
    t_atab      n_atab;
    t_atab      r_atab;

    assign a0 = i_endpoints[7:0];
    assign a1 = i_endpoints[15:8];
    assign ge = (a0 >= a1);

    always_comb begin
        for (int k = 1; k <= 6; k++) begin
            if (ge) begin
                n_sum[k-1] = {3'b000, a0} * 11'(7 - k) + {3'b000, a1} * 11'(k);
            end else if (k <= 4) begin
                n_sum[k-1] = {3'b000, a0} * 11'(5 - k) + {3'b000, a1} * 11'(k);
            end else begin
                n_sum[k-1] = 11'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_load) begin
            r_sum <= n_sum;
            r_ge  <= ge;
            r_a0  <= a0;
            r_a1  <= a1;
        end
    end

    always_comb begin
        n_atab[0] = r_a0;
        n_atab[1] = r_a1;
        for (int j = 0; j < 6; j++) begin
            q7[j] = {12'd0, r_sum[j]} * Recip7;
            q5[j] = {12'd0, r_sum[j]} * Recip5;
            n_atab[j+2] = r_ge ? q7[j][Shift7 +: 8] : q5[j][Shift5 +: 8];
        end
        if (!r_ge) begin
            n_atab[6] = 8'h00;
            n_atab[7] = 8'hff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_load) begin
            r_atab <= n_atab;
        end
    end

    assign o_atab = r_atab;

endmodule

[rtl/core/atcd_serializer.sv]
// Pixel serialiser: walks one decoded block and emits its sixteen pixels in order.
module atcd_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  atcd_pkg::t_ctx i_ctx,
    output logic           o_free,
    output logic           o_pixel_valid,
    output logic [1:0]     o_pixel_col,
    output logic [1:0]     o_pixel_row,
    output logic [31:0]    o_pixel_argb,
    output logic           o_last_pixel
);
    import atcd_pkg::*;

    t_ctx        r_ctx;
    logic        r_valid;
    logic [3:0]  r_cnt;
    logic [1:0]  ci;
    logic [3:0]  nib;
    logic [2:0]  ai;
    logic [7:0]  alpha;
    logic        r_o_valid;
    logic [1:0]  r_o_col;
    logic [1:0]  r_o_row;
    logic [31:0] r_o_argb;
    logic        r_o_last;

    assign o_free = !r_valid || (r_cnt == 4'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 4'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= 4'd0;
        end else if (r_valid) begin
            if (r_cnt == 4'd15) begin
                r_valid <= 1'b0;
            end
            r_cnt <= r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctx <= i_ctx;
        end
    end

    always_comb begin
        ci  = 2'(r_ctx.idx >> {r_cnt, 1'b0});
        nib = 4'(r_ctx.abits >> {r_cnt, 2'b00});
        ai  = 3'(r_ctx.abits[63:16] >> ({2'b00, r_cnt} * 6'd3));
        case (r_ctx.mode)
            MODE_OPAQUE:   alpha = 8'hff;
            MODE_EXPLICIT: alpha = {nib, nib};
            MODE_INTERP:   alpha = r_ctx.atab[ai];
            default:       alpha = 8'hff;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_col  <= r_cnt[1:0];
        r_o_row  <= r_cnt[3:2];
        r_o_argb <= {alpha, r_ctx.pal[ci]};
        r_o_last <= (r_cnt == 4'd15);
    end

    assign o_pixel_valid = r_o_valid;
    assign o_pixel_col   = r_o_col;
    assign o_pixel_row   = r_o_row;
    assign o_pixel_argb  = r_o_argb;
    assign o_last_pixel  = r_o_last;

    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last |-> r_o_col == 2'd3 && r_o_row == 2'd3)
        else $error("Last pixel flagged away from the bottom-right corner.");

    a_block_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_last |=> r_o_valid)
        else $error("Pixel stream of a block was broken off.");

    a_pixel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_last |=> {r_o_row, r_o_col} == $past({r_o_row, r_o_col}) + 4'd1)
        else $error("Pixels of a block left raster order.");

endmodule

[rtl/core/atc_texture_block_decoder_core.sv]
// Top level of the ATC texture block decoder: request pipeline and pixel output.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+------------------------------------------------
//   request  | start / busy            | i_base_color_a, i_base_color_b,
//            |                         | i_color_indices, i_alpha_bits
//   pixel    | o_pixel_valid (strobe)  | o_pixel_col, o_pixel_row, o_pixel_argb,
//            |                         | o_last_pixel
//   config   | i_cfg_we                | i_cfg_wdata (alpha mode)
//
// A request is taken when start is high and busy is low. Each block yields sixteen
// pixels, one per cycle, and the single pixel serialiser sets the sustained rate. A
// request passes the input register, the palette and alpha stage registers and the
// serialiser's context and output registers. Up to three further requests queue
// in the palette and alpha stages while a block is emitted; busy rises when they
// are full. A request taken in alpha mode three produces no pixels. Reset clears
// all valid bits and sets the alpha mode to opaque. The receiver cannot stall.
module atc_texture_block_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_base_color_a,
    input  logic [15:0] i_base_color_b,
    input  logic [31:0] i_color_indices,
    input  logic [63:0] i_alpha_bits,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output logic        o_pixel_valid,
    output logic [1:0]  o_pixel_col,
    output logic [1:0]  o_pixel_row,
    output logic [31:0] o_pixel_argb,
    output logic        o_last_pixel
);
    import atcd_pkg::*;

    t_alpha_mode r_alpha_mode;

    logic        r_s1_valid;
    t_alpha_mode r_s1_mode;
    logic [15:0] r_s1_c0;
    logic [15:0] r_s1_c1;
    logic [31:0] r_s1_idx;
    logic [63:0] r_s1_abits;

    logic        r_s2_valid;
    t_alpha_mode r_s2_mode;
    logic [31:0] r_s2_idx;
    logic [63:0] r_s2_abits;

    logic        r_s3_valid;
    t_alpha_mode r_s3_mode;
    logic [31:0] r_s3_idx;
    logic [63:0] r_s3_abits;

    logic       ser_free;
    logic       ser_load;
    logic       s1_ready;
    logic       s2_ready;
    logic       s3_ready;
    logic       accept;
    t_stage_ctl ctl;
    t_pal       pal;
    t_atab      atab;
    t_ctx       ctx;

    assign s3_ready    = !r_s3_valid || ser_free;
    assign s2_ready    = !r_s2_valid || s3_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign busy        = !s1_ready;
    assign accept      = start && s1_ready;
    assign ctl.s2_load = r_s1_valid && s2_ready;
    assign ctl.s3_load = r_s2_valid && s3_ready;
    assign ser_load    = r_s3_valid && ser_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode <= MODE_OPAQUE;
        end else if (i_cfg_we) begin
            r_alpha_mode <= t_alpha_mode'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= (r_alpha_mode != MODE_OFF);
            end else if (ctl.s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (ctl.s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (ctl.s3_load) begin
                r_s2_valid <= 1'b0;
            end
            if (ctl.s3_load) begin
                r_s3_valid <= 1'b1;
            end else if (ser_load) begin
                r_s3_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode  <= r_alpha_mode;
            r_s1_c0    <= i_base_color_a;
            r_s1_c1    <= i_base_color_b;
            r_s1_idx   <= i_color_indices;
            r_s1_abits <= i_alpha_bits;
        end
        if (ctl.s2_load) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_idx   <= r_s1_idx;
            r_s2_abits <= r_s1_abits;
        end
        if (ctl.s3_load) begin
            r_s3_mode  <= r_s2_mode;
            r_s3_idx   <= r_s2_idx;
            r_s3_abits <= r_s2_abits;
        end
    end

    atcd_palette u_palette (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_color_a (r_s1_c0),
        .i_color_b (r_s1_c1),
        .o_pal     (pal)
    );

    atcd_alpha u_alpha (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_endpoints (r_s1_abits[15:0]),
        .o_atab      (atab)
    );

    assign ctx.pal   = pal;
    assign ctx.atab  = atab;
    assign ctx.idx   = r_s3_idx;
    assign ctx.abits = r_s3_abits;
    assign ctx.mode  = r_s3_mode;

    atcd_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (ser_load),
        .i_ctx         (ctx),
        .o_free        (ser_free),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_col   (o_pixel_col),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_argb  (o_pixel_argb),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the ATC texture block decoder core, with its own pixel predictor.
module tb_top;
    import atcd_pkg::*;

    typedef struct {
        logic [1:0]  col;
        logic [1:0]  row;
        logic [31:0] argb;
        logic        last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_base_color_a = '0;
    logic [15:0] i_base_color_b = '0;
    logic [31:0] i_color_indices = '0;
    logic [63:0] i_alpha_bits = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        o_pixel_valid;
    logic [1:0]  o_pixel_col;
    logic [1:0]  o_pixel_row;
    logic [31:0] o_pixel_argb;
    logic        o_last_pixel;

    t_alpha_mode alpha_mode_q = MODE_OPAQUE;
    t_pixel      pending_pixels[$];
    bit          idle_on = 1'b1;
    int          fail_count = 0;
    int          pixel_count = 0;
    int          block_count = 0;
    int          dropped_count = 0;

    atc_texture_block_decoder_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_base_color_a  (i_base_color_a),
        .i_base_color_b  (i_base_color_b),
        .i_color_indices (i_color_indices),
        .i_alpha_bits    (i_alpha_bits),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_col     (o_pixel_col),
        .o_pixel_row     (o_pixel_row),
        .o_pixel_argb    (o_pixel_argb),
        .o_last_pixel    (o_last_pixel)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] blend_third(input logic [7:0] near, input logic [7:0] far);
        logic [15:0] acc;
        acc = (16'(near) << 1) + 16'(far);
        acc = acc * 16'd21;
        return acc[13:6];
    endfunction

    function automatic logic [7:0] alpha_ramp(input logic [7:0] a0, input logic [7:0] a1,
                                              input logic [2:0] sel);
        int k;
        k = int'(sel) - 1;
        if (sel == 3'd0) return a0;
        if (sel == 3'd1) return a1;
        if (a0 >= a1) return 8'((int'(a0) * (7 - k) + int'(a1) * k) / 7);
        if (sel == 3'd6) return 8'd0;
        if (sel == 3'd7) return 8'd255;
        return 8'((int'(a0) * (5 - k) + int'(a1) * k) / 5);
    endfunction

    task automatic predict_block(input logic [15:0] ca, input logic [15:0] cb,
                                 input logic [31:0] ci, input logic [63:0] ab);
        logic [7:0]  r0, g0, b0, r1, g1, b1;
        logic [31:0] rb_diff;
        logic [15:0] g_diff;
        logic [23:0] pal [4];
        logic [7:0]  alpha;
        t_pixel      px;
        r0 = {ca[14:10], 3'b000};
        g0 = {ca[9:4], ca[9:8]};
        b0 = {ca[4:0], 3'b000};
        r1 = {cb[15:11], 3'b000};
        g1 = {cb[10:5], cb[10:9]};
        b1 = {cb[4:0], 3'b000};
        // The variant entry borrows across channels exactly as the packed-word subtraction does.
        rb_diff = {8'h00, r0, 8'h00, b0} - ({8'h00, r1, 8'h00, b1} >> 2);
        g_diff = {g0, 8'h00} - ({g1, 8'h00} >> 2);
        if (!ca[15]) begin
            pal[0] = {r0, g0, b0};
            pal[1] = {blend_third(r0, r1), blend_third(g0, g1), blend_third(b0, b1)};
            pal[2] = {blend_third(r1, r0), blend_third(g1, g0), blend_third(b1, b0)};
        end else begin
            pal[0] = 24'h000000;
            pal[1] = {rb_diff[23:16], g_diff[15:8], rb_diff[7:0]};
            pal[2] = {r0, g0, b0};
        end
        pal[3] = {r1, g1, b1};
        for (int i = 0; i < 16; i++) begin
            case (alpha_mode_q)
                MODE_OPAQUE:   alpha = 8'hff;
                MODE_EXPLICIT: alpha = {ab[4*i +: 4], ab[4*i +: 4]};
                default:       alpha = alpha_ramp(ab[7:0], ab[15:8], ab[16+3*i +: 3]);
            endcase
            px.col = 2'(i);
            px.row = 2'(i >> 2);
            px.argb = {alpha, pal[ci[2*i +: 2]]};
            px.last = (i == 15);
            pending_pixels.push_back(px);
        end
    endtask

    task automatic send_block(input logic [15:0] ca, input logic [15:0] cb,
                              input logic [31:0] ci, input logic [63:0] ab);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_base_color_a <= ca;
        i_base_color_b <= cb;
        i_color_indices <= ci;
        i_alpha_bits <= ab;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (alpha_mode_q == MODE_OFF) begin
            dropped_count++;
        end else begin
            block_count++;
            predict_block(ca, cb, ci, ab);
        end
    endtask

    task automatic drain_pixels();
        @(negedge i_clk) start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic set_alpha_mode(input t_alpha_mode mode);
        drain_pixels();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk) alpha_mode_q = mode;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    task automatic test_opaque_palettes();
        send_block(16'h0000, 16'h0000, 32'h00000000, {$urandom, $urandom});
        send_block(16'h7fff, 16'hffff, 32'he4e4e4e4, {$urandom, $urandom});
        send_block(16'hffff, 16'h0000, 32'h1b1b1b1b, {$urandom, $urandom});
        send_block(16'h8000, 16'hffff, 32'he4e4e4e4, 64'hffffffffffffffff);
        send_block(16'h5555, 16'haaaa, 32'h55555555, 64'h0000000000000000);
    endtask

    task automatic test_explicit_alpha();
        set_alpha_mode(MODE_EXPLICIT);
        send_block(16'h1234, 16'hfedc, 32'he4e4e4e4, 64'hfedcba9876543210);
        send_block(16'h8421, 16'h7bde, 32'h1b1b1b1b, 64'h0000000000000000);
        send_block(16'hffff, 16'hffff, 32'hffffffff, 64'hffffffffffffffff);
        send_block(16'h0000, 16'h0000, 32'h00000000, 64'h0123456789abcdef);
    endtask

    task automatic test_interpolated_alpha();
        set_alpha_mode(MODE_INTERP);
        send_block(16'h7c1f, 16'h07e0, 32'he4e4e4e4, {48'hfac688fac688, 8'd0, 8'd255});
        send_block(16'h83e0, 16'hf81f, 32'h1b1b1b1b, {48'hfac688fac688, 8'd255, 8'd0});
        send_block(16'h4210, 16'h8410, 32'he4e4e4e4, {48'hfac688fac688, 8'd128, 8'd128});
        send_block(16'h2a6b, 16'h5d4c, 32'h9c9c9c9c, {48'hfac688fac688, 8'd13, 8'd200});
        send_block(16'hd6b5, 16'h39c7, 32'h36363636, {48'hfac688fac688, 8'd200, 8'd13});
        send_block(16'hffff, 16'hffff, 32'hffffffff, 64'hffffffffffffffff);
        send_block(16'h0000, 16'h0000, 32'h00000000, 64'h0000000000000000);
    endtask

    task automatic test_disabled_mode();
        set_alpha_mode(MODE_OFF);
        repeat (3) send_block(16'($urandom), 16'($urandom), $urandom, {$urandom, $urandom});
    endtask

    task automatic test_random_blocks();
        t_alpha_mode phase_modes [6];
        int          phase_items [6];
        logic [63:0] ab;
        phase_modes = '{MODE_INTERP, MODE_OPAQUE, MODE_EXPLICIT, MODE_OFF, MODE_INTERP,
                        MODE_EXPLICIT};
        phase_items = '{55, 45, 50, 5, 55, 50};
        for (int p = 0; p < 6; p++) begin
            set_alpha_mode(phase_modes[p]);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 5) idle_on = 1'b0;
                else if (n % 16 == 0) idle_on = $urandom_range(0, 1);
                ab = {$urandom, $urandom};
                if ($urandom_range(0, 7) == 0) ab[15:8] = ab[7:0];
                send_block(16'($urandom), 16'($urandom), $urandom, ab);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_pixel_valid) begin
            pixel_count++;
            if (pending_pixels.size() == 0) begin
                $error("Unexpected pixel: row %0d col %0d argb %h last %b",
                       o_pixel_row, o_pixel_col, o_pixel_argb, o_last_pixel);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_col !== want.col) begin
                    $error("pixel_col: expected %0d, got %0d", want.col, o_pixel_col);
                    fail_count++;
                end
                if (o_pixel_row !== want.row) begin
                    $error("pixel_row: expected %0d, got %0d", want.row, o_pixel_row);
                    fail_count++;
                end
                if (o_pixel_argb !== want.argb) begin
                    $error("pixel_argb: expected %h, got %h", want.argb, o_pixel_argb);
                    fail_count++;
                end
                if (o_last_pixel !== want.last) begin
                    $error("last_pixel: expected %b, got %b", want.last, o_last_pixel);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_opaque_palettes();
        test_explicit_alpha();
        test_interpolated_alpha();
        test_disabled_mode();
        test_random_blocks();
        drain_pixels();
        $display("Decoded %0d blocks into %0d checked pixels over opaque, explicit and %s",
                 block_count, pixel_count, "interpolated alpha with both palette variants.");
        $display("A further %0d requests were sent with alpha disabled and gave no pixels.",
                 dropped_count);
        if (fail_count == 0) begin
            $display("atc_texture_block_decoder_core: match");
        end else begin
            $display("atc_texture_block_decoder_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("atc_texture_block_decoder_core: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/core/atcd_pkg.sv
rtl/core/atcd_palette.sv
rtl/core/atcd_alpha.sv
rtl/core/atcd_serializer.sv
rtl/core/atc_texture_block_decoder_core.sv
tb/tb_top.sv
